// ----- design/midi_step_sequencer_defines.svh -----
// Assertion macros shared by the step sequencer RTL.
`ifndef MIDI_STEP_SEQUENCER_DEFINES_SVH
`define MIDI_STEP_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

// a in this cycle implies b in the same cycle
`define MSS_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// a in this cycle implies b in the next cycle
`define MSS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error(msg);

`else

`define MSS_ASSERT_IMPLY(label, clk, rst_n, a, b, msg)
`define MSS_ASSERT_NEXT(label, clk, rst_n, a, b, msg)

`endif

`endif

// ----- design/mss_pkg.sv -----
// Package: function codes, register indexes, word layouts and controller states.
`timescale 1ns / 1ps

package mss_pkg;

	// input, output and configuration word widths
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_DATA_W  = 4;

	// function codes
	localparam logic [2:0] FUNC_CLOCK      = 3'd0;
	localparam logic [2:0] FUNC_WRITE_STEP = 3'd1;
	localparam logic [2:0] FUNC_WRITE_LEN  = 3'd2;
	localparam logic [2:0] FUNC_START      = 3'd3;
	localparam logic [2:0] FUNC_STOP       = 3'd4;
	localparam logic [2:0] FUNC_TOGGLE     = 3'd5;
	localparam logic [2:0] FUNC_READ_STEP  = 3'd6;

	// configuration register indexes
	localparam logic CFG_PATTERN_SELECT = 1'b0;
	localparam logic CFG_ONE_SHOT       = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MOD,
		ST_RESP
	} ctrl_state_t;

endpackage

// ----- design/midi_step_sequencer.sv -----
// Step sequencer channel: step memory, pattern lengths, index advance and word output.
`timescale 1ns / 1ps
`include "midi_step_sequencer_defines.svh"

// One channel of a step sequencer. Steps live in a synchronous single-port-read
// step memory (one row of SLOT_USED steps for each of the PAT_USED patterns); pattern
// lengths sit in reset flip-flops, so no clearing pass follows reset. Every input
// word first reads the step memory into a register; an item that emits nothing
// then finishes from LOOK, or waits in RESP while the output is still full. A falling
// sequencer clock that emits a step also runs the index wrap, (index + 1) mod
// length, through a restoring remainder unit that handles one bit per cycle,
// LW bits in all, LW being the bit width of the longest pattern length. One item
// is in flight at a time; the result register lets the next word in while a
// result still waits on the output.
module midi_step_sequencer #(
	parameter int PATTERN_COUNT     = 16,
	parameter int STEPS_PER_PATTERN = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// [2:0] func, [3] clock_level, [7:4] pattern_addr, [12:8] step_slot,
	// [20:13] step_channel, [28:21] step_type, [36:29] step_first_data,
	// [44:37] step_second_data, [50:45] new_length, [55:51] zero
	input  logic [mss_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] out_channel, [15:8] out_type, [23:16] out_first_data,
	// [31:24] out_second_data, [32] is_running, [37:33] position, [39:38] zero
	output logic [mss_pkg::OUT_TDATA_W-1:0] m_tdata,
	// [0] message_valid
	output logic                           m_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [mss_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import mss_pkg::*;

	// patterns and slots reachable through the 4-bit and 5-bit address fields
	localparam int PAT_USED  = (PATTERN_COUNT < 16) ? PATTERN_COUNT : 16;
	localparam int SLOT_USED = (STEPS_PER_PATTERN < 32) ? STEPS_PER_PATTERN : 32;
	localparam int DEPTH     = PAT_USED * SLOT_USED;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW        = (PAT_USED > 1) ? $clog2(PAT_USED) : 1;
	// longest storable length, limited by the 6-bit length field
	localparam int LEN_MAX   = (STEPS_PER_PATTERN < 63) ? STEPS_PER_PATTERN : 63;
	localparam int LW        = $clog2(LEN_MAX + 1);
	localparam int IW        = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;
	localparam int CW        = (LW > 1) ? $clog2(LW) : 1;

	// input fields
	logic [2:0] in_func;
	logic       in_level;
	logic [3:0] in_pattern;
	logic [4:0] in_slot;
	logic [31:0] in_word;
	logic [5:0] in_length;
	logic       in_addr_ok;
	logic [9:0] in_addr_full;
	logic [9:0] clk_addr_full;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [LW-1:0] in_len_sat;

	// storage
	logic [31:0]   step_mem [DEPTH];
	logic [31:0]   rdata_q;
	logic [LW-1:0] len_q [PAT_USED];

	// channel state
	logic [3:0]    pattern_select_q;
	logic          one_shot_q;
	logic [IW-1:0] current_step_q;
	logic          running_q;
	logic          last_clk_q;

	// item in flight
	logic          emit_s1;
	logic          rd_ok_s1;
	logic [LW-1:0] len_s1;

	// remainder unit
	logic [LW-1:0] rem_q;
	logic [LW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic [LW:0]   trial;
	logic [LW-1:0] rem_next;

	// control
	ctrl_state_t   state_q;
	ctrl_state_t   state_next;
	logic          accept;
	logic          iterate;
	logic          finish;
	logic          out_free;
	logic          sel_ok;
	logic [LW-1:0] len_sel;
	logic          emit_now;
	logic [IW-1:0] fin_step;
	logic          fin_running;
	logic [31:0]   fin_word;

	// output register
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tuser_q;
	logic                   m_tvalid_q;

	// unpack the input word
	assign in_func    = s_tdata[2:0];
	assign in_level   = s_tdata[3];
	assign in_pattern = s_tdata[7:4];
	assign in_slot    = s_tdata[12:8];
	assign in_word    = {s_tdata[20:13], s_tdata[28:21], s_tdata[36:29], s_tdata[44:37]};
	assign in_length  = s_tdata[50:45];

	// step memory addresses
	assign in_addr_ok    = (int'(in_pattern) < PAT_USED) && (int'(in_slot) < SLOT_USED);
	assign in_addr_full  = 10'(in_pattern) * 10'(SLOT_USED) + 10'(in_slot);
	assign clk_addr_full = 10'(pattern_select_q) * 10'(SLOT_USED) + 10'(current_step_q);
	assign wr_addr       = AW'(in_addr_full);

	always_comb begin
		if (in_func == FUNC_READ_STEP) begin
			rd_addr = AW'(in_addr_full);
		end else if (int'(clk_addr_full) < DEPTH) begin
			rd_addr = AW'(clk_addr_full);
		end else begin
			rd_addr = '0;
		end
	end

	// saturate a written length
	assign in_len_sat = (int'(in_length) > STEPS_PER_PATTERN) ?
		LW'(STEPS_PER_PATTERN) : LW'(in_length);

	// length of the selected pattern; out-of-range patterns read as empty
	assign sel_ok  = int'(pattern_select_q) < PAT_USED;
	assign len_sel = sel_ok ? len_q[pattern_select_q[PW-1:0]] : '0;

	// falling clock edge on a running channel with a non-empty pattern
	assign emit_now = (in_func == FUNC_CLOCK) && running_q && (in_level != last_clk_q)
		&& !in_level && (len_sel != '0);

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// step memory: write on a step write, read on every accepted word
	always_ff @(posedge clk) begin
		if (accept && (in_func == FUNC_WRITE_STEP) && in_addr_ok) begin
			step_mem[wr_addr] <= in_word;
		end
		if (accept) begin
			rdata_q <= step_mem[rd_addr];
		end
	end

	// one restoring remainder step per cycle
	assign trial    = {rem_q, div_q[LW-1]};
	assign rem_next = (trial >= {1'b0, len_s1}) ? LW'(trial - {1'b0, len_s1}) : trial[LW-1:0];

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (emit_s1) begin
					state_next = (cnt_q == '0) ? ST_RESP : ST_MOD;
				end else if (!out_free) begin
					state_next = ST_RESP;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_MOD: begin
				if (cnt_q == '0) begin
					state_next = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// controller outputs
	always_comb begin
		s_tready = 1'b0;
		iterate  = 1'b0;
		finish   = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_LOOK: begin
				iterate = emit_s1;
				finish  = !emit_s1 && out_free;
			end
			ST_MOD:  iterate = 1'b1;
			ST_RESP: finish = out_free;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// post-item values of the channel
	always_comb begin
		if (emit_s1) begin
			fin_step    = IW'(rem_q);
			fin_running = !(one_shot_q && (rem_q == '0));
		end else begin
			fin_step    = current_step_q;
			fin_running = running_q;
		end
		fin_word = (emit_s1 || rd_ok_s1) ? rdata_q : '0;
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_select_q <= '0;
			one_shot_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN_SELECT: pattern_select_q <= cfg_data[3:0];
				CFG_ONE_SHOT:       one_shot_q <= cfg_data[0];
				default:            one_shot_q <= one_shot_q;
			endcase
		end
	end

	// pattern lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAT_USED; i++) begin
				len_q[i] <= '0;
			end
		end else if (accept && (in_func == FUNC_WRITE_LEN) && (int'(in_pattern) < PAT_USED)) begin
			len_q[in_pattern[PW-1:0]] <= in_len_sat;
		end
	end

	// run control, clock level and step index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_step_q <= '0;
			running_q      <= 1'b0;
			last_clk_q     <= 1'b0;
		end else if (accept) begin
			case (in_func)
				FUNC_CLOCK: begin
					if (running_q) begin
						last_clk_q <= in_level;
					end
				end
				FUNC_START: begin
					current_step_q <= '0;
					running_q      <= 1'b1;
				end
				FUNC_STOP: running_q <= 1'b0;
				FUNC_TOGGLE: begin
					if (running_q) begin
						running_q <= 1'b0;
					end else begin
						current_step_q <= '0;
						running_q      <= 1'b1;
					end
				end
				default: begin
					running_q <= running_q;
				end
			endcase
		end else if (finish) begin
			current_step_q <= fin_step;
			running_q      <= fin_running;
		end
	end

	// item flags, held until the item finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1  <= 1'b0;
			rd_ok_s1 <= 1'b0;
		end else if (accept) begin
			emit_s1  <= emit_now;
			rd_ok_s1 <= (in_func == FUNC_READ_STEP) && in_addr_ok;
		end
	end

	// remainder unit: load (index + 1) on accept, then shift one bit a cycle for an emitting item
	always_ff @(posedge clk) begin
		if (accept) begin
			len_s1 <= len_sel;
			div_q  <= LW'(current_step_q) + LW'(1);
			rem_q  <= '0;
			cnt_q  <= CW'(LW - 1);
		end else if (iterate) begin
			rem_q <= rem_next;
			div_q <= div_q << 1;
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tuser_q <= emit_s1;
			m_tdata_q <= {2'b00, 5'(fin_step), fin_running,
				fin_word[7:0], fin_word[15:8], fin_word[23:16], fin_word[31:24]};
		end
	end

	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tvalid = m_tvalid_q;

	// one item at a time
	`MSS_ASSERT_NEXT(a_one_item, clk, arst_n, accept, !s_tready,
		"input accepted again before the item finished")
	// the remainder unit only runs for emitting clock items
	`MSS_ASSERT_IMPLY(a_mod_emit, clk, arst_n, state_q == ST_MOD, emit_s1,
		"remainder unit running for an item that emits nothing")
	// the partial remainder stays below the pattern length
	`MSS_ASSERT_IMPLY(a_rem_range, clk, arst_n, iterate, (rem_q < len_s1),
		"partial remainder not below pattern length")
	// a result is only loaded when the output slot is free
	`MSS_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, finish, (!m_tvalid || m_tready),
		"result loaded over a word still waiting")

endmodule

// ----- dv/midi_step_sequencer_test.sv -----
// Testbench for the step sequencer channel: stream stimulus, step prediction and result checks.
`timescale 1ns / 1ps

module midi_step_sequencer_test;
	import mss_pkg::*;

	localparam logic [2:0] FUNC_UNUSED = 3'd7;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 150;

	typedef struct {
		logic [2:0] func;
		logic       level;
		logic [3:0] pat;
		logic [4:0] slot;
		logic [7:0] chan;
		logic [7:0] kind;
		logic [7:0] data0;
		logic [7:0] data1;
		logic [5:0] len;
	} seq_item_t;

	typedef struct {
		logic       msg_valid;
		logic [7:0] chan;
		logic [7:0] kind;
		logic [7:0] data0;
		logic [7:0] data1;
		logic       running;
		logic [4:0] pos;
	} seq_result_t;

	// Predicts each result from its own copy of the channel state
	class sequencer_scoreboard;
		logic [31:0] steps [512];
		bit          written [512];
		logic [5:0]  lengths [16];
		logic [4:0]  index;
		bit          running;
		bit          last_clk;
		logic [3:0]  sel;
		bit          one_shot;
		seq_result_t pending_results [$];
		int          errors;

		function new();
			foreach (lengths[i]) lengths[i] = '0;
			foreach (written[i]) written[i] = 0;
			foreach (steps[i]) steps[i] = '0;
			index = '0;
			running = 0;
			last_clk = 0;
			sel = '0;
			one_shot = 0;
			errors = 0;
		endfunction

		function void set_config(logic [3:0] pattern, bit once);
			sel = pattern;
			one_shot = once;
		endfunction

		// Address of the step an item would read, or -1 when it reads none
		function int read_addr(seq_item_t it);
			if (it.func == FUNC_READ_STEP)
				return int'({it.pat, it.slot});
			if (it.func == FUNC_CLOCK && running && it.level != last_clk && !it.level &&
					lengths[sel] != 0)
				return int'({sel, index});
			return -1;
		endfunction

		function void note_word(seq_item_t it);
			seq_result_t exp;
			logic [31:0] word;
			int next_index;

			exp = '{default: '0};
			case (it.func)
				FUNC_CLOCK: begin
					if (running && it.level != last_clk) begin
						last_clk = it.level;
						if (!it.level && lengths[sel] != 0) begin
							word = steps[{sel, index}];
							exp.msg_valid = 1'b1;
							{exp.chan, exp.kind, exp.data0, exp.data1} = word;
							next_index = (int'(index) + 1) % int'(lengths[sel]);
							index = next_index[4:0];
							if (one_shot && index == 0)
								running = 0;
						end
					end
				end
				FUNC_WRITE_STEP: begin
					steps[{it.pat, it.slot}] = {it.chan, it.kind, it.data0, it.data1};
					written[{it.pat, it.slot}] = 1;
				end
				FUNC_WRITE_LEN: lengths[it.pat] = (it.len > 6'd32) ? 6'd32 : it.len;
				FUNC_START: begin
					index = '0;
					running = 1;
				end
				FUNC_STOP: running = 0;
				FUNC_TOGGLE: begin
					if (running) begin
						running = 0;
					end else begin
						index = '0;
						running = 1;
					end
				end
				FUNC_READ_STEP: {exp.chan, exp.kind, exp.data0, exp.data1} =
					steps[{it.pat, it.slot}];
				default: ;
			endcase
			exp.running = running;
			exp.pos = index;
			pending_results.push_back(exp);
		endfunction

		function void compare_field(string name, logic [31:0] e, logic [31:0] g);
			if (g !== e) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, g);
				errors++;
			end
		endfunction

		function void check_word(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
			seq_result_t exp;

			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, actual %0h user %0h",
					$time, tdata, tuser);
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			compare_field("message_valid", 32'(exp.msg_valid), 32'(tuser));
			compare_field("out_channel", 32'(exp.chan), 32'(tdata[7:0]));
			compare_field("out_type", 32'(exp.kind), 32'(tdata[15:8]));
			compare_field("out_first_data", 32'(exp.data0), 32'(tdata[23:16]));
			compare_field("out_second_data", 32'(exp.data1), 32'(tdata[31:24]));
			compare_field("is_running", 32'(exp.running), 32'(tdata[32]));
			compare_field("position", 32'(exp.pos), 32'(tdata[37:33]));
			compare_field("pad", 32'd0, 32'(tdata[39:38]));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	sequencer_scoreboard sb = new();
	bit idle_on = 1'b1;

	midi_step_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic seq_item_t make_item(logic [2:0] func, logic [3:0] pat,
			logic [4:0] slot, logic [31:0] word, logic [5:0] len, logic level);
		seq_item_t it;
		it.func = func;
		it.level = level;
		it.pat = pat;
		it.slot = slot;
		{it.chan, it.kind, it.data0, it.data1} = word;
		it.len = len;
		return it;
	endfunction

	// Draw a random word; mostly clock edges and writes around the playing pattern
	function automatic seq_item_t random_item();
		seq_item_t it;
		int r;
		int addr;

		it = make_item(3'($urandom), 4'($urandom), 5'($urandom), $urandom,
			6'($urandom), 1'($urandom));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			it.func = FUNC_CLOCK;
			it.level = ($urandom_range(0, 4) != 0) ? !sb.last_clk : sb.last_clk;
		end else if (r < 60) begin
			it.func = FUNC_WRITE_STEP;
			if ($urandom_range(0, 9) < 7)
				it.pat = sb.sel;
		end else if (r < 67) begin
			it.func = FUNC_WRITE_LEN;
			if ($urandom_range(0, 9) < 7)
				it.pat = sb.sel;
			r = $urandom_range(0, 9);
			if (r < 7)
				it.len = 6'($urandom_range(1, 6));
			else if (r < 8)
				it.len = '0;
		end else if (r < 75) begin
			it.func = FUNC_START;
		end else if (r < 79) begin
			it.func = FUNC_STOP;
		end else if (r < 85) begin
			it.func = FUNC_TOGGLE;
		end else if (r < 97) begin
			it.func = FUNC_READ_STEP;
		end else begin
			it.func = FUNC_UNUSED;
		end

		// Fill a step before anything reads it
		addr = sb.read_addr(it);
		if (addr >= 0 && !sb.written[addr[8:0]]) begin
			it.func = FUNC_WRITE_STEP;
			it.pat = addr[8:5];
			it.slot = addr[4:0];
		end
		return it;
	endfunction

	// Present one word, after a random gap while idle_on is set, and hold it until accepted
	task automatic send_item(seq_item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {5'd0, it.len, it.data1, it.data0, it.kind, it.chan, it.slot, it.pat,
			it.level, it.func};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		sb.note_word(it);
	endtask

	task automatic write_config(logic [3:0] pattern, bit once);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PATTERN_SELECT;
		cfg_data <= pattern;
		@(posedge clk);
		cfg_index <= CFG_ONE_SHOT;
		cfg_data <= {3'($urandom), once};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(pattern, once);
	endtask

	// Accept result words, with random stalls while idle_on is set
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1)
				@(posedge clk);
			sb.check_word(m_tdata, m_tuser);
		end
	end

	// Main sequence: directed words, then random phases under several settings
	initial begin
		seq_item_t directed [$];
		logic [3:0] pattern;
		bit once;

		directed.push_back(make_item(FUNC_WRITE_STEP, 4'd0, 5'd0, 32'hFFFF_FFFF, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_WRITE_STEP, 4'd0, 5'd1, 32'h0000_0000, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_WRITE_STEP, 4'd15, 5'd31, 32'hA55A_C33C, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_WRITE_LEN, 4'd0, 5'd0, 32'd0, 6'd2, 1'b0));
		// saturated length
		directed.push_back(make_item(FUNC_WRITE_LEN, 4'd15, 5'd0, 32'd0, 6'd63, 1'b0));
		directed.push_back(make_item(FUNC_READ_STEP, 4'd15, 5'd31, 32'd0, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_READ_STEP, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		// clock while stopped is ignored
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b1));
		directed.push_back(make_item(FUNC_START, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b1));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b1));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b1));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b1));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		// shorten to a length equal to the index, then emit from past the end of the pattern
		directed.push_back(make_item(FUNC_WRITE_LEN, 4'd0, 5'd0, 32'd0, 6'd1, 1'b0));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b1));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		// zero length emits nothing
		directed.push_back(make_item(FUNC_WRITE_LEN, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b1));
		directed.push_back(make_item(FUNC_CLOCK, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_STOP, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_TOGGLE, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_TOGGLE, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));
		directed.push_back(make_item(FUNC_UNUSED, 4'd0, 5'd0, 32'd0, 6'd0, 1'b0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < PHASES; phase++) begin
			// Extremes first, then random settings
			case (phase)
				0: begin pattern = 4'd0; once = 1'b0; end
				1: begin pattern = 4'd15; once = 1'b1; end
				2: begin pattern = 4'd0; once = 1'b1; end
				3: begin pattern = 4'd15; once = 1'b0; end
				default: begin pattern = 4'($urandom); once = 1'($urandom); end
			endcase
			idle_on = (phase % 4) != 3;
			write_config(pattern, once);
			if (phase == 0)
				foreach (directed[i]) send_item(directed[i]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(random_item());
			s_tvalid <= 1'b0;
			// Hold the settings until every result is back
			while (sb.pending_results.size() > 0)
				@(posedge clk);
		end

		repeat (20) @(posedge clk);
		if (sb.pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				sb.pending_results.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
